// ===== rtl/ffba_pkg.sv =====
`default_nettype none

package ffba_pkg;

    localparam int ADDR_BITS       = 10;
    localparam int SIZE_BITS       = ADDR_BITS + 1;
    localparam int MAX_FREE_BLOCKS = 128;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = SIZE_BITS;

    localparam logic [ADDR_BITS-1:0] POOL_BASE_RST = ADDR_BITS'(64);
    localparam logic [SIZE_BITS-1:0] POOL_SIZE_RST = SIZE_BITS'(960);

    typedef enum logic [1:0] {
        ACT_CHECK   = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_ZERO_SIZE  = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_POOL_BASE = 1'b0,
        REG_POOL_SIZE = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_INSERT,
        OP_REMOVE,
        OP_SHRINK,
        OP_MERGE
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FIND,
        S_APPLY,
        S_ADJ,
        S_AFIND,
        S_MERGE
    } t_state;

    typedef struct packed {
        t_cell_op               op;
        logic [ADDR_BITS-1:0]   new_start;
        logic [SIZE_BITS-1:0]   new_size;
        logic [SIZE_BITS-1:0]   req;
        logic [ADDR_BITS-1:0]   rel;
    } t_cell_cmd;

    typedef struct packed {
        logic fit;
        logic eq;
        logic ge;
        logic gt;
        logic adj;
    } t_cell_flag;

endpackage

`default_nettype wire

// ===== rtl/ffba_cell.sv =====
`default_nettype none

module ffba_cell (
    input  wire                                 i_clk,
    input  wire                                 i_head,
    input  wire ffba_pkg::t_cell_cmd            i_cmd,
    input  wire                                 i_sel,
    input  wire                                 i_after,
    input  wire [ffba_pkg::ADDR_BITS-1:0]       i_left_start,
    input  wire [ffba_pkg::SIZE_BITS-1:0]       i_left_size,
    input  wire [ffba_pkg::ADDR_BITS-1:0]       i_right_start,
    input  wire [ffba_pkg::SIZE_BITS-1:0]       i_right_size,
    output logic [ffba_pkg::ADDR_BITS-1:0]      o_start,
    output logic [ffba_pkg::SIZE_BITS-1:0]      o_size,
    output ffba_pkg::t_cell_flag                o_flag
);

    logic [ffba_pkg::ADDR_BITS-1:0] r_start;
    logic [ffba_pkg::ADDR_BITS-1:0] n_start;
    logic [ffba_pkg::SIZE_BITS-1:0] r_size;
    logic [ffba_pkg::SIZE_BITS-1:0] n_size;
    logic [ffba_pkg::SIZE_BITS:0]   sum;
    logic [ffba_pkg::SIZE_BITS:0]   end_addr;

    always_comb begin
        sum     = {1'b0, r_size} + {1'b0, i_right_size};
        n_start = r_start;
        n_size  = r_size;
        case (i_cmd.op)
            ffba_pkg::OP_INIT: begin
                if (i_head) begin
                    n_start = i_cmd.new_start;
                    n_size  = i_cmd.new_size;
                end
            end
            ffba_pkg::OP_INSERT: begin
                if (i_sel) begin
                    n_start = i_cmd.new_start;
                    n_size  = i_cmd.new_size;
                end else if (i_after) begin
                    n_start = i_left_start;
                    n_size  = i_left_size;
                end
            end
            ffba_pkg::OP_REMOVE: begin
                if (i_sel || i_after) begin
                    n_start = i_right_start;
                    n_size  = i_right_size;
                end
            end
            ffba_pkg::OP_SHRINK: begin
                if (i_sel) begin
                    n_start = r_start + i_cmd.req[ffba_pkg::ADDR_BITS-1:0];
                    n_size  = r_size - i_cmd.req;
                end
            end
            ffba_pkg::OP_MERGE: begin
                if (i_sel) begin
                    // saturating size
                    n_size = sum[ffba_pkg::SIZE_BITS] ? '1 : sum[ffba_pkg::SIZE_BITS-1:0];
                end else if (i_after) begin
                    n_start = i_right_start;
                    n_size  = i_right_size;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
        r_size  <= n_size;
    end

    always_comb begin
        end_addr   = (ffba_pkg::SIZE_BITS+1)'(r_start) + (ffba_pkg::SIZE_BITS+1)'(r_size);
        o_flag.fit = (r_size >= i_cmd.req);
        o_flag.eq  = (r_size == i_cmd.req);
        o_flag.ge  = (r_start >= i_cmd.rel);
        o_flag.gt  = (r_start > i_cmd.rel);
        o_flag.adj = (end_addr == (ffba_pkg::SIZE_BITS+1)'(i_right_start));
    end

    assign o_start = r_start;
    assign o_size  = r_size;

endmodule

`default_nettype wire

// ===== rtl/ffba_ctrl.sv =====
`default_nettype none

module ffba_ctrl #(
    parameter int MAX_FREE_BLOCKS = ffba_pkg::MAX_FREE_BLOCKS
) (
    input  wire                                             i_clk,
    input  wire                                             i_rst_n,
    input  wire                                             start,
    input  wire [1:0]                                       i_action,
    input  wire [ffba_pkg::SIZE_BITS-1:0]                   i_request_size,
    input  wire [ffba_pkg::ADDR_BITS-1:0]                   i_release_start,
    input  wire                                             i_cfg_we,
    input  wire [ffba_pkg::CFG_IDX_BITS-1:0]                i_cfg_index,
    input  wire [ffba_pkg::CFG_DATA_BITS-1:0]               i_cfg_data,
    input  wire ffba_pkg::t_cell_flag [MAX_FREE_BLOCKS:0]   i_flag,
    input  wire [MAX_FREE_BLOCKS:0][ffba_pkg::ADDR_BITS-1:0] i_start,
    output logic                                            busy,
    output logic                                            o_valid,
    output logic                                            o_granted,
    output logic [ffba_pkg::ADDR_BITS-1:0]                  o_block_start,
    output logic [1:0]                                      o_status,
    output ffba_pkg::t_cell_cmd                             o_cmd,
    output logic [MAX_FREE_BLOCKS:0]                        o_sel,
    output logic [MAX_FREE_BLOCKS:0]                        o_after
);

    localparam int CELLS    = MAX_FREE_BLOCKS + 1;
    localparam int CNT_BITS = $clog2(MAX_FREE_BLOCKS + 2);
    localparam int LEVELS   = $clog2(CELLS);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(CELLS);
    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);

    ffba_pkg::t_state               r_state;
    ffba_pkg::t_state               n_state;
    logic [1:0]                     r_action;
    logic [1:0]                     n_action;
    logic [ffba_pkg::SIZE_BITS-1:0] r_req;
    logic [ffba_pkg::SIZE_BITS-1:0] n_req;
    logic [ffba_pkg::ADDR_BITS-1:0] r_rel;
    logic [ffba_pkg::ADDR_BITS-1:0] n_rel;
    logic [CNT_BITS-1:0]            r_count;
    logic [CNT_BITS-1:0]            n_count;
    logic [CELLS-1:0]               r_hit;
    logic [CELLS-1:0]               n_hit;
    logic [CELLS-1:0]               r_sel;
    logic [CELLS-1:0]               n_sel;
    logic [CELLS-1:0]               r_after;
    logic [CELLS-1:0]               n_after;
    logic                           r_any;
    logic                           n_any;
    logic [ffba_pkg::ADDR_BITS-1:0] r_pool_base;
    logic [ffba_pkg::ADDR_BITS-1:0] n_pool_base;
    logic [ffba_pkg::SIZE_BITS-1:0] r_pool_size;
    logic [ffba_pkg::SIZE_BITS-1:0] n_pool_size;
    logic                           r_valid;
    logic                           n_valid;
    logic                           r_granted;
    logic                           n_granted;
    logic [ffba_pkg::ADDR_BITS-1:0] r_block_start;
    logic [ffba_pkg::ADDR_BITS-1:0] n_block_start;
    ffba_pkg::t_status              r_status;
    ffba_pkg::t_status              n_status;

    logic                           accept;
    logic                           known_action;
    logic [CELLS-1:0]               valid_vec;
    logic [CELLS-1:0]               fit_vec;
    logic [CELLS-1:0]               eq_vec;
    logic [CELLS-1:0]               pos_vec;
    logic [CELLS-1:0]               adj_vec;
    logic [CELLS-1:0]               prefix;
    logic [CELLS-1:0]               beyond;
    logic [CELLS-1:0]               first;
    logic [ffba_pkg::ADDR_BITS-1:0] sel_start;
    logic                           sel_eq;

    assign busy         = (r_state != ffba_pkg::S_IDLE);
    assign accept       = start && !busy;
    assign known_action = (i_action == ffba_pkg::ACT_CHECK) ||
                          (i_action == ffba_pkg::ACT_ALLOC) ||
                          (i_action == ffba_pkg::ACT_RELEASE);

    // per-cell match vectors
    always_comb begin
        for (int i = 0; i < CELLS; i++) begin
            valid_vec[i] = (CNT_BITS'(i) < r_count);
            fit_vec[i]   = valid_vec[i] & i_flag[i].fit;
            eq_vec[i]    = i_flag[i].eq;
            pos_vec[i]   = !valid_vec[i] | ((i == 0) ? i_flag[i].gt : i_flag[i].ge);
        end
        for (int i = 0; i < CELLS - 1; i++) begin
            adj_vec[i] = valid_vec[i+1] & i_flag[i].adj;
        end
        adj_vec[CELLS-1] = 1'b0;
    end

    // find first set bit, log-depth prefix or
    always_comb begin
        prefix = r_hit;
        for (int k = 0; k < LEVELS; k++) begin
            prefix = prefix | (prefix << (1 << k));
        end
        beyond = prefix << 1;
        first  = r_hit & ~beyond;
    end

    always_comb begin
        sel_start = '0;
        for (int i = 0; i < CELLS; i++) begin
            sel_start = sel_start | ({ffba_pkg::ADDR_BITS{r_sel[i]}} & i_start[i]);
        end
        sel_eq = |(r_sel & eq_vec);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_IDLE: begin
                if (accept && known_action && (i_request_size != '0)) begin
                    n_state = ffba_pkg::S_CMP;
                end
            end
            ffba_pkg::S_CMP:   n_state = ffba_pkg::S_FIND;
            ffba_pkg::S_FIND:  n_state = ffba_pkg::S_APPLY;
            ffba_pkg::S_APPLY: begin
                n_state = (r_action == ffba_pkg::ACT_RELEASE) ? ffba_pkg::S_ADJ
                                                              : ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_ADJ: begin
                n_state = (|adj_vec) ? ffba_pkg::S_AFIND : ffba_pkg::S_IDLE;
            end
            ffba_pkg::S_AFIND: n_state = ffba_pkg::S_MERGE;
            ffba_pkg::S_MERGE: n_state = ffba_pkg::S_ADJ;
            default:           n_state = ffba_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_action      = r_action;
        n_req         = r_req;
        n_rel         = r_rel;
        n_count       = r_count;
        n_hit         = r_hit;
        n_sel         = r_sel;
        n_after       = r_after;
        n_any         = r_any;
        n_pool_base   = r_pool_base;
        n_pool_size   = r_pool_size;
        n_valid       = 1'b0;
        n_granted     = r_granted;
        n_block_start = r_block_start;
        n_status      = r_status;
        o_cmd.op        = ffba_pkg::OP_HOLD;
        o_cmd.new_start = r_rel;
        o_cmd.new_size  = r_req;
        o_cmd.req       = r_req;
        o_cmd.rel       = r_rel;

        case (r_state)
            ffba_pkg::S_IDLE: begin
                if (accept) begin
                    n_action = i_action;
                    n_req    = i_request_size;
                    n_rel    = i_release_start;
                    if (!known_action) begin
                        n_valid       = 1'b1;
                        n_granted     = 1'b0;
                        n_block_start = '0;
                        n_status      = ffba_pkg::ST_OK;
                    end else if (i_request_size == '0) begin
                        n_valid       = 1'b1;
                        n_granted     = 1'b0;
                        n_block_start = '0;
                        n_status      = ffba_pkg::ST_ZERO_SIZE;
                    end
                end
            end
            ffba_pkg::S_CMP: begin
                n_hit = (r_action == ffba_pkg::ACT_RELEASE) ? pos_vec : fit_vec;
            end
            ffba_pkg::S_FIND, ffba_pkg::S_AFIND: begin
                n_sel   = first;
                n_after = beyond;
                n_any   = prefix[CELLS-1];
            end
            ffba_pkg::S_APPLY: begin
                case (r_action)
                    ffba_pkg::ACT_CHECK: begin
                        n_valid       = 1'b1;
                        n_granted     = r_any;
                        n_block_start = '0;
                        n_status      = r_any ? ffba_pkg::ST_OK : ffba_pkg::ST_NO_FIT;
                    end
                    ffba_pkg::ACT_ALLOC: begin
                        n_valid = 1'b1;
                        if (r_any) begin
                            o_cmd.op      = sel_eq ? ffba_pkg::OP_REMOVE : ffba_pkg::OP_SHRINK;
                            n_count       = sel_eq ? (r_count - CNT_ONE) : r_count;
                            n_granted     = 1'b1;
                            n_block_start = sel_start;
                            n_status      = ffba_pkg::ST_OK;
                        end else begin
                            n_granted     = 1'b0;
                            n_block_start = '0;
                            n_status      = ffba_pkg::ST_NO_FIT;
                        end
                    end
                    ffba_pkg::ACT_RELEASE: begin
                        o_cmd.op = ffba_pkg::OP_INSERT;
                        n_count  = r_count + CNT_ONE;
                    end
                    default: begin
                    end
                endcase
            end
            ffba_pkg::S_ADJ: begin
                n_hit = adj_vec;
                if (!(|adj_vec)) begin
                    n_valid       = 1'b1;
                    n_block_start = '0;
                    if (r_count == CNT_FULL) begin
                        // no merge took place: undo the insert
                        o_cmd.op  = ffba_pkg::OP_REMOVE;
                        n_count   = r_count - CNT_ONE;
                        n_granted = 1'b0;
                        n_status  = ffba_pkg::ST_TABLE_FULL;
                    end else begin
                        n_granted = 1'b1;
                        n_status  = ffba_pkg::ST_OK;
                    end
                end
            end
            ffba_pkg::S_MERGE: begin
                o_cmd.op = ffba_pkg::OP_MERGE;
                n_count  = r_count - CNT_ONE;
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            if (i_cfg_index == ffba_pkg::REG_POOL_BASE) begin
                n_pool_base = i_cfg_data[ffba_pkg::ADDR_BITS-1:0];
            end else begin
                n_pool_size = i_cfg_data[ffba_pkg::SIZE_BITS-1:0];
            end
            o_cmd.op        = ffba_pkg::OP_INIT;
            o_cmd.new_start = n_pool_base;
            o_cmd.new_size  = n_pool_size;
            n_count         = (n_pool_size == '0) ? '0 : CNT_ONE;
        end

        if (!i_rst_n) begin
            o_cmd.op        = ffba_pkg::OP_INIT;
            o_cmd.new_start = ffba_pkg::POOL_BASE_RST;
            o_cmd.new_size  = ffba_pkg::POOL_SIZE_RST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ffba_pkg::S_IDLE;
            r_count     <= CNT_ONE;
            r_pool_base <= ffba_pkg::POOL_BASE_RST;
            r_pool_size <= ffba_pkg::POOL_SIZE_RST;
            r_valid     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pool_base <= n_pool_base;
            r_pool_size <= n_pool_size;
            r_valid     <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action      <= n_action;
        r_req         <= n_req;
        r_rel         <= n_rel;
        r_hit         <= n_hit;
        r_sel         <= n_sel;
        r_after       <= n_after;
        r_any         <= n_any;
        r_granted     <= n_granted;
        r_block_start <= n_block_start;
        r_status      <= n_status;
    end

    assign o_valid       = r_valid;
    assign o_granted     = r_granted;
    assign o_block_start = r_block_start;
    assign o_status      = r_status;
    assign o_sel         = r_sel;
    assign o_after       = r_after;

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
`default_nettype none

// First-fit allocator over a pool of addresses, free blocks held in a row of cells in
// ascending start order. A word is taken when start is high and busy is low; its result
// appears for exactly one cycle with o_valid and cannot be held off. A zero size or an
// unknown action answers in the cycle after acceptance. Check and allocate pass through
// a compare in which all cells compare at once, the registered find-first over the row,
// and an apply step that applies the change and registers the result for the ports. A
// release runs the same steps, with the insert in the apply step, and then an adjacency
// compare precedes the result; each neighbor merge costs a find-first, a shift of the
// row and another adjacency compare. The table is ready straight out of reset, and a
// configuration write reloads it to one block (none if the size is zero) in the same
// cycle.
module first_fit_block_allocator #(
    parameter int MAX_FREE_BLOCKS = ffba_pkg::MAX_FREE_BLOCKS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [1:0]                           i_action,
    input  wire [ffba_pkg::SIZE_BITS-1:0]       i_request_size,
    input  wire [ffba_pkg::ADDR_BITS-1:0]       i_release_start,
    output logic                                o_valid,
    output logic                                o_granted,
    output logic [ffba_pkg::ADDR_BITS-1:0]      o_block_start,
    output logic [1:0]                          o_status,
    input  wire                                 i_cfg_we,
    input  wire [ffba_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  wire [ffba_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int CELLS = MAX_FREE_BLOCKS + 1;

    ffba_pkg::t_cell_cmd                        cmd;
    logic [CELLS-1:0]                           sel;
    logic [CELLS-1:0]                           after;
    ffba_pkg::t_cell_flag [CELLS-1:0]           flag;
    logic [CELLS-1:0][ffba_pkg::ADDR_BITS-1:0]  cell_start;
    logic [CELLS-1:0][ffba_pkg::SIZE_BITS-1:0]  cell_size;

    ffba_ctrl #(
        .MAX_FREE_BLOCKS(MAX_FREE_BLOCKS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_action       (i_action),
        .i_request_size (i_request_size),
        .i_release_start(i_release_start),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_flag         (flag),
        .i_start        (cell_start),
        .busy           (busy),
        .o_valid        (o_valid),
        .o_granted      (o_granted),
        .o_block_start  (o_block_start),
        .o_status       (o_status),
        .o_cmd          (cmd),
        .o_sel          (sel),
        .o_after        (after)
    );

    for (genvar i = 0; i < CELLS; i++) begin : g_cell
        localparam int LEFT  = (i == 0) ? 0 : i - 1;
        localparam int RIGHT = (i == CELLS - 1) ? i : i + 1;

        ffba_cell u_cell (
            .i_clk        (i_clk),
            .i_head       (i == 0),
            .i_cmd        (cmd),
            .i_sel        (sel[i]),
            .i_after      (after[i]),
            .i_left_start (cell_start[LEFT]),
            .i_left_size  (cell_size[LEFT]),
            .i_right_start(cell_start[RIGHT]),
            .i_right_size (cell_size[RIGHT]),
            .o_start      (cell_start[i]),
            .o_size       (cell_size[i]),
            .o_flag       (flag[i])
        );
    end

endmodule

`default_nettype wire

// ===== rtl/ffba_checker.sv =====
`default_nettype none

module ffba_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    input  wire                             busy,
    input  wire [1:0]                       i_action,
    input  wire [ffba_pkg::SIZE_BITS-1:0]   i_request_size,
    input  wire                             o_valid,
    input  wire                             o_granted,
    input  wire [ffba_pkg::ADDR_BITS-1:0]   o_block_start,
    input  wire [1:0]                       o_status
);

    logic known_action;

    assign known_action = (i_action == ffba_pkg::ACT_CHECK) ||
                          (i_action == ffba_pkg::ACT_ALLOC) ||
                          (i_action == ffba_pkg::ACT_RELEASE);

    a_granted_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_granted |-> o_status == ffba_pkg::ST_OK)
        else $error("granted word with non-ok status");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_granted |-> o_block_start == '0)
        else $error("block start set on a word that was not granted");

    a_zero_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && known_action && (i_request_size == '0)
        |=> o_valid && !busy && (o_status == ffba_pkg::ST_ZERO_SIZE))
        else $error("zero size request not answered at once");

    a_work_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && known_action && (i_request_size != '0)
        |=> busy && !o_valid)
        else $error("accepted request did not start work");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result word while still busy");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_action      (i_action),
    .i_request_size(i_request_size),
    .o_valid       (o_valid),
    .o_granted     (o_granted),
    .o_block_start (o_block_start),
    .o_status      (o_status)
);

`default_nettype wire

// ===== tb/first_fit_block_allocator_test.sv =====
`timescale 1ns / 1ps

module first_fit_block_allocator_test;

    localparam int AB          = ffba_pkg::ADDR_BITS;
    localparam int SB          = ffba_pkg::SIZE_BITS;
    localparam int NBLK        = ffba_pkg::MAX_FREE_BLOCKS;
    localparam int NROWS       = 25;
    localparam int PHASES      = 15;
    localparam int PHASE_WORDS = 86;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int TAIL_CYCLES = 400;

    localparam logic [1:0]    ACT_SPARE = 2'd3;
    localparam logic [SB-1:0] SIZE_MAX  = {SB{1'b1}};

    typedef struct packed {
        logic              granted;
        logic [AB-1:0]     blk_start;
        ffba_pkg::t_status status;
    } t_answer;

    typedef struct packed {
        logic               is_reg;
        ffba_pkg::t_cfg_reg reg_idx;
        logic [1:0]         act;
        logic [SB-1:0]      size;
        logic [AB-1:0]      rel;
        logic               known;
        t_answer            ans;
    } t_script_row;

    logic                                 i_clk;
    logic                                 i_rst_n;
    logic                                 start;
    logic                                 busy;
    logic [1:0]                           i_action;
    logic [SB-1:0]                        i_request_size;
    logic [AB-1:0]                        i_release_start;
    logic                                 o_valid;
    logic                                 o_granted;
    logic [AB-1:0]                        o_block_start;
    logic [1:0]                           o_status;
    logic                                 i_cfg_we;
    logic [ffba_pkg::CFG_IDX_BITS-1:0]    i_cfg_index;
    logic [ffba_pkg::CFG_DATA_BITS-1:0]   i_cfg_data;

    first_fit_block_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_action        (i_action),
        .i_request_size  (i_request_size),
        .i_release_start (i_release_start),
        .o_valid         (o_valid),
        .o_granted       (o_granted),
        .o_block_start   (o_block_start),
        .o_status        (o_status),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // free block table as the allocator should hold it
    logic [AB-1:0] free_start_tab [NBLK];
    logic [SB-1:0] free_size_tab [NBLK];
    int            free_n;
    logic [AB-1:0] pool_base_reg;
    logic [SB-1:0] pool_size_reg;

    t_answer       answers_due [$];
    logic [AB-1:0] held_start [$];
    logic [SB-1:0] held_size [$];

    int   mismatches;
    int   cycles;
    logic idle_on;

    function automatic t_script_row req_row(logic [1:0] act, logic [SB-1:0] size,
                                            logic [AB-1:0] rel);
        t_script_row row;
        row = '0;
        row.act = act;
        row.size = size;
        row.rel = rel;
        return row;
    endfunction

    function automatic t_script_row known_row(logic [1:0] act, logic [SB-1:0] size,
                                              logic [AB-1:0] rel, logic g,
                                              logic [AB-1:0] s, ffba_pkg::t_status st);
        t_script_row row;
        row = req_row(act, size, rel);
        row.known = 1'b1;
        row.ans.granted = g;
        row.ans.blk_start = s;
        row.ans.status = st;
        return row;
    endfunction

    function automatic t_script_row reg_row(ffba_pkg::t_cfg_reg idx, logic [SB-1:0] val);
        t_script_row row;
        row = '0;
        row.is_reg = 1'b1;
        row.reg_idx = idx;
        row.size = val;
        return row;
    endfunction

    t_script_row script [NROWS] = '{
        known_row(ffba_pkg::ACT_CHECK,   960,  0,    1'b1, 0,    ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_CHECK,   961,  0,    1'b0, 0,    ffba_pkg::ST_NO_FIT),
        known_row(ffba_pkg::ACT_ALLOC,   0,    0,    1'b0, 0,    ffba_pkg::ST_ZERO_SIZE),
        known_row(ACT_SPARE,             5,    1023, 1'b0, 0,    ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_ALLOC,   16,   0,    1'b1, 64,   ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_ALLOC,   1024, 0,    1'b0, 0,    ffba_pkg::ST_NO_FIT),
        known_row(ffba_pkg::ACT_ALLOC,   2047, 0,    1'b0, 0,    ffba_pkg::ST_NO_FIT),
        known_row(ffba_pkg::ACT_RELEASE, 16,   64,   1'b1, 0,    ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_RELEASE, 0,    0,    1'b0, 0,    ffba_pkg::ST_ZERO_SIZE),
        known_row(ffba_pkg::ACT_ALLOC,   960,  0,    1'b1, 64,   ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_CHECK,   1,    0,    1'b0, 0,    ffba_pkg::ST_NO_FIT),
        known_row(ffba_pkg::ACT_RELEASE, 1,    1023, 1'b1, 0,    ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_RELEASE, 1023, 0,    1'b1, 0,    ffba_pkg::ST_OK),
        known_row(ffba_pkg::ACT_ALLOC,   1024, 0,    1'b1, 0,    ffba_pkg::ST_OK),
        reg_row(ffba_pkg::REG_POOL_BASE, 1000),
        reg_row(ffba_pkg::REG_POOL_SIZE, 1024),
        known_row(ffba_pkg::ACT_ALLOC,   30,   0,    1'b1, 1000, ffba_pkg::ST_OK),
        // start of the shrunk block wraps past the top address
        known_row(ffba_pkg::ACT_ALLOC,   1,    0,    1'b1, 6,    ffba_pkg::ST_OK),
        req_row(ffba_pkg::ACT_RELEASE,   30,   1000),
        req_row(ffba_pkg::ACT_RELEASE,   5,    7),
        req_row(ffba_pkg::ACT_CHECK,     2047, 0),
        reg_row(ffba_pkg::REG_POOL_SIZE, 0),
        known_row(ffba_pkg::ACT_CHECK,   1,    0,    1'b0, 0,    ffba_pkg::ST_NO_FIT),
        known_row(ffba_pkg::ACT_RELEASE, 1024, 1023, 1'b1, 0,    ffba_pkg::ST_OK),
        known_row(ACT_SPARE,             0,    0,    1'b0, 0,    ffba_pkg::ST_OK)
    };

    task automatic load_pool();
        int i;
        for (i = 0; i < NBLK; i++) begin
            free_start_tab[i] = '0;
            free_size_tab[i] = '0;
        end
        free_n = (pool_size_reg == 0) ? 0 : 1;
        free_start_tab[0] = pool_base_reg;
        free_size_tab[0] = pool_size_reg;
        held_start.delete();
        held_size.delete();
    endtask

    task automatic pool_release(input logic [AB-1:0] s, input logic [SB-1:0] z,
                                output ffba_pkg::t_status st);
        logic [AB-1:0] ws [NBLK+1];
        logic [SB-1:0] wz [NBLK+1];
        logic [SB:0]   sum;
        int            p, m, i, k;
        if (free_n == 0 || s < free_start_tab[0]) begin
            p = 0;
        end else begin
            p = 1;
            while (p < free_n && free_start_tab[p] < s) p++;
        end
        for (i = 0; i < p; i++) begin
            ws[i] = free_start_tab[i];
            wz[i] = free_size_tab[i];
        end
        ws[p] = s;
        wz[p] = z;
        for (i = p; i < free_n; i++) begin
            ws[i+1] = free_start_tab[i];
            wz[i+1] = free_size_tab[i];
        end
        m = free_n + 1;
        i = 0;
        while (i + 1 < m) begin
            if (int'(ws[i]) + int'(wz[i]) == int'(ws[i+1])) begin
                sum = {1'b0, wz[i]} + {1'b0, wz[i+1]};
                wz[i] = (sum > {1'b0, SIZE_MAX}) ? SIZE_MAX : sum[SB-1:0];
                for (k = i + 1; k + 1 < m; k++) begin
                    ws[k] = ws[k+1];
                    wz[k] = wz[k+1];
                end
                m--;
            end else begin
                i++;
            end
        end
        if (m > NBLK) begin
            st = ffba_pkg::ST_TABLE_FULL;
        end else begin
            for (i = 0; i < m; i++) begin
                free_start_tab[i] = ws[i];
                free_size_tab[i] = wz[i];
            end
            free_n = m;
            st = ffba_pkg::ST_OK;
        end
    endtask

    task automatic serve_request(input logic [1:0] act, input logic [SB-1:0] req,
                                 input logic [AB-1:0] rel, output t_answer ans);
        ffba_pkg::t_status st;
        int                i, k;
        ans = '0;
        ans.status = ffba_pkg::ST_OK;
        if (act == ACT_SPARE) begin
            ans.status = ffba_pkg::ST_OK;
        end else if (req == 0) begin
            ans.status = ffba_pkg::ST_ZERO_SIZE;
        end else if (act == ffba_pkg::ACT_CHECK || act == ffba_pkg::ACT_ALLOC) begin
            ans.status = ffba_pkg::ST_NO_FIT;
            for (i = 0; i < free_n; i++) begin
                if (free_size_tab[i] >= req) begin
                    ans.granted = 1'b1;
                    ans.status = ffba_pkg::ST_OK;
                    if (act == ffba_pkg::ACT_ALLOC) begin
                        ans.blk_start = free_start_tab[i];
                        if (free_size_tab[i] == req) begin
                            for (k = i; k + 1 < free_n; k++) begin
                                free_start_tab[k] = free_start_tab[k+1];
                                free_size_tab[k] = free_size_tab[k+1];
                            end
                            free_n--;
                        end else begin
                            free_start_tab[i] = free_start_tab[i] + req[AB-1:0];
                            free_size_tab[i] = free_size_tab[i] - req;
                        end
                    end
                    break;
                end
            end
        end else begin
            pool_release(rel, req, st);
            ans.status = st;
            ans.granted = (st == ffba_pkg::ST_OK);
        end
    endtask

    task automatic issue(input logic [1:0] act, input logic [SB-1:0] req,
                         input logic [AB-1:0] rel, input logic use_typed,
                         input t_answer typed);
        t_answer ans;
        int      gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_action <= act;
        i_request_size <= req;
        i_release_start <= rel;
        do @(posedge i_clk); while (busy);
        serve_request(act, req, rel, ans);
        if (act == ffba_pkg::ACT_ALLOC && ans.granted) begin
            held_start.push_back(ans.blk_start);
            held_size.push_back(req);
        end
        answers_due.push_back(use_typed ? typed : ans);
    endtask

    task automatic drain();
        @(negedge i_clk);
        start <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input ffba_pkg::t_cfg_reg idx, input logic [SB-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == ffba_pkg::REG_POOL_BASE) pool_base_reg = val[AB-1:0];
        else pool_size_reg = val;
        load_pool();
    endtask

    function automatic logic [SB-1:0] pick_size();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return SB'($urandom_range(1, 32));
        if (r < 9) return SB'($urandom_range(1, 256));
        return SB'($urandom_range(1, 2047));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_valid) begin
            if (answers_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word g=%0d start=%0d st=%0d", $realtime,
                             o_granted, o_block_start, o_status);
            end else begin
                want = answers_due.pop_front();
                if (o_granted !== want.granted || o_block_start !== want.blk_start ||
                    o_status !== want.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: exp g=%0d s=%0d st=%0d got g=%0d s=%0d st=%0d",
                                 $realtime, want.granted, want.blk_start, want.status,
                                 o_granted, o_block_start, o_status);
                end
            end
        end
    end

    initial begin
        int            row, ph, k, r, idx;
        logic [SB-1:0] base_v, size_v;
        logic [1:0]    act;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_action = '0;
        i_request_size = '0;
        i_release_start = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = ffba_pkg::REG_POOL_BASE;
        i_cfg_data = '0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1'b1;
        pool_base_reg = ffba_pkg::POOL_BASE_RST;
        pool_size_reg = ffba_pkg::POOL_SIZE_RST;
        load_pool();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (row = 0; row < NROWS; row++) begin
            if (script[row].is_reg) begin
                drain();
                write_reg(script[row].reg_idx, script[row].size);
            end else begin
                issue(script[row].act, script[row].size, script[row].rel,
                      script[row].known, script[row].ans);
            end
        end

        // scattered single-unit releases into an empty pool until the table overflows
        drain();
        write_reg(ffba_pkg::REG_POOL_BASE, 0);
        write_reg(ffba_pkg::REG_POOL_SIZE, 0);
        for (k = 0; k < NBLK + 2; k++) begin
            issue(ffba_pkg::ACT_RELEASE, 1, AB'(2 * k), 1'b0, '0);
        end

        for (ph = 0; ph < PHASES; ph++) begin
            drain();
            case (ph)
                0: begin base_v = 0; size_v = 1024; end
                1: begin base_v = 1023; size_v = 1; end
                2: begin base_v = 1023; size_v = 1024; end
                3: begin base_v = SB'($urandom_range(0, 2047)); size_v = 2047; end
                default: begin
                    base_v = SB'($urandom_range(0, 2047));
                    size_v = ($urandom_range(0, 9) == 0) ? SB'($urandom_range(0, 2047))
                                                         : SB'($urandom_range(1, 1024));
                end
            endcase
            if ($urandom_range(0, 1)) begin
                write_reg(ffba_pkg::REG_POOL_BASE, base_v);
                write_reg(ffba_pkg::REG_POOL_SIZE, size_v);
            end else begin
                write_reg(ffba_pkg::REG_POOL_SIZE, size_v);
                write_reg(ffba_pkg::REG_POOL_BASE, base_v);
            end
            idle_on = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            for (k = 0; k < PHASE_WORDS; k++) begin
                if (k == PHASE_WORDS / 2 && (ph == 3 || $urandom_range(0, 1) == 0)) drain();
                r = $urandom_range(0, 99);
                if (r < 40 || (r < 70 && held_start.size() == 0)) begin
                    issue(ffba_pkg::ACT_ALLOC, pick_size(), AB'($urandom), 1'b0, '0);
                end else if (r < 70) begin
                    idx = $urandom_range(0, held_start.size() - 1);
                    issue(ffba_pkg::ACT_RELEASE, held_size[idx], held_start[idx], 1'b0, '0);
                    held_start.delete(idx);
                    held_size.delete(idx);
                end else if (r < 82) begin
                    issue(ffba_pkg::ACT_CHECK, pick_size(), AB'($urandom), 1'b0, '0);
                end else if (r < 90) begin
                    issue(ffba_pkg::ACT_RELEASE, pick_size(), AB'($urandom_range(0, 1023)),
                          1'b0, '0);
                end else if (r < 95) begin
                    act = 2'($urandom_range(0, 2));
                    issue(act, 0, AB'($urandom), 1'b0, '0);
                end else begin
                    issue(ACT_SPARE, SB'($urandom_range(0, 2047)), AB'($urandom), 1'b0, '0);
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/ffba_ctrl.sv
rtl/first_fit_block_allocator.sv
rtl/ffba_checker.sv
tb/first_fit_block_allocator_test.sv
